[src/fwcb_pkg.sv]
// shared types and constants of the flash write-combining buffer
package fwcb_pkg;

    // word geometry (word size must be a power of two)
    localparam int unsigned WORD_BYTES = 8;
    localparam int unsigned OFF_W      = $clog2(WORD_BYTES);
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned VALUE_W    = 64;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;

    // output queue default depth (power of two, at least 8)
    localparam int unsigned FIFO_DEPTH = 8;

    localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_LENGTH = 8'd1;

    // input modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // result kinds
    localparam logic KIND_PROGRAM = 1'b0;
    localparam logic KIND_DISCARD = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [ADDR_W-1:0]   word_address;
        logic [VALUE_W-1:0]  word_value;
        logic                last;
    } t_result;

    // up to two results pushed per processed item, first one oldest
    typedef struct packed {
        logic [1:0] num;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

[src/fwcb_merge.sv]
// word buffer state and the single-pass merge / flush logic
module fwcb_merge (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_mode,
    input  logic [fwcb_pkg::ADDR_W-1:0] i_address,
    input  logic [fwcb_pkg::BYTE_W-1:0] i_data_byte,
    input  logic [fwcb_pkg::ADDR_W:0]   i_limit,
    output fwcb_pkg::t_push             o_push
);
    import fwcb_pkg::*;

    typedef logic [WORD_BYTES-1:0][BYTE_W-1:0] t_bytes;

    logic [ADDR_W-1:0] r_baddr, n_baddr;
    logic              r_valid, n_valid;
    logic              r_dirty, n_dirty;
    t_bytes            r_bytes, n_bytes;

    logic              push_a, push_b;
    t_result           res_a, res_b;
    logic [OFF_W-1:0]  off;
    logic [ADDR_W-1:0] aligned;
    logic              flushable;
    logic              change;

    function automatic t_result make_result(input logic [ADDR_W-1:0] addr,
                                            input t_bytes bytes,
                                            input logic [ADDR_W:0] limit);
        t_result r;
        r.kind         = ({1'b0, addr} >= limit) ? KIND_DISCARD : KIND_PROGRAM;
        r.word_address = addr;
        r.word_value   = VALUE_W'(bytes);
        r.last         = 1'b1;
        return r;
    endfunction

    // merge the item into the buffer, collect flushed words
    always_comb begin
        n_baddr   = r_baddr;
        n_valid   = r_valid;
        n_dirty   = r_dirty;
        n_bytes   = r_bytes;
        push_a    = 1'b0;
        push_b    = 1'b0;
        off       = i_address[OFF_W-1:0];
        aligned   = {i_address[ADDR_W-1:OFF_W], {OFF_W{1'b0}}};
        flushable = r_valid && r_dirty;
        change    = !r_valid || (aligned != r_baddr);
        res_a     = make_result(r_baddr, r_bytes, i_limit);
        res_b     = res_a;
        if (i_valid) begin
            if (i_mode == MODE_FLUSH) begin
                if (flushable) begin
                    push_a  = 1'b1;
                    n_bytes = {WORD_BYTES{ERASED_BYTE}};
                    n_baddr = '0;
                    n_valid = 1'b0;
                    n_dirty = 1'b0;
                end
            end else begin
                // word change: old word goes out if dirty, a clean buffer is all erased
                if (change) begin
                    push_a  = flushable;
                    n_bytes = {WORD_BYTES{ERASED_BYTE}};
                    n_baddr = aligned;
                    n_valid = 1'b1;
                end
                n_bytes[off] = i_data_byte;
                n_dirty      = 1'b1;
                // last byte of the word: flush it and move to the next word
                if (off == OFF_W'(WORD_BYTES - 1)) begin
                    push_b  = 1'b1;
                    res_b   = make_result(n_baddr, n_bytes, i_limit);
                    n_bytes = {WORD_BYTES{ERASED_BYTE}};
                    n_dirty = 1'b0;
                    n_baddr = n_baddr + ADDR_W'(WORD_BYTES);
                    n_valid = 1'b1;
                end
            end
        end
    end

    // compact the results for the output queue
    always_comb begin
        o_push.num    = 2'd0;
        o_push.first  = res_a;
        o_push.second = res_b;
        if (push_a && push_b) begin
            o_push.num        = 2'd2;
            o_push.first.last = 1'b0;
        end else if (push_a) begin
            o_push.num = 2'd1;
        end else if (push_b) begin
            o_push.num   = 2'd1;
            o_push.first = res_b;
        end
    end

    // buffer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baddr <= '0;
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
            r_bytes <= {WORD_BYTES{ERASED_BYTE}};
        end else begin
            r_baddr <= n_baddr;
            r_valid <= n_valid;
            r_dirty <= n_dirty;
            r_bytes <= n_bytes;
        end
    end

endmodule

[src/fwcb_out_fifo.sv]
// result queue taking up to two results per cycle, one beat out per cycle while i_ready is high
module fwcb_out_fifo #(
    parameter int unsigned DEPTH = fwcb_pkg::FIFO_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fwcb_pkg::t_push              i_push,
    output fwcb_pkg::t_result            o_head,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    import fwcb_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [PTR_W-1:0]   wr_next;
    logic               pop;

    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign o_count = r_cnt;
    assign pop     = o_valid && i_ready;
    assign wr_next = r_wr + PTR_W'(1);

    // pointer and count update
    always_comb begin
        n_wr  = r_wr + PTR_W'(i_push.num);
        n_rd  = r_rd + PTR_W'(pop);
        n_cnt = r_cnt + CNT_W'(i_push.num) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_next] <= i_push.second;
        end
    end

endmodule

[src/flash_write_combining_buffer_core.sv]
// top level of the flash write-combining buffer
//
//  channel   | direction | handshake                     | payload
//  ----------+-----------+-------------------------------+---------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready | tuser mode, tdata address+byte
//  m_axis    | out       | m_axis_tvalid / m_axis_tready | tuser kind, tdata addr+word, tlast
//  cfg       | in        | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
//  one beat per cycle in while s_axis_tready is high; the item is registered, merged in
//  the next cycle and its results land in the output queue
//  an item that flushes two words gives two output beats; the queue absorbs
//  this and s_axis_tready drops when it could not hold two results for the item in
//  flight plus two for a new one
//  synchronous reset clears the buffer (no word held, bytes erased), the region
//  registers and the queue; config writes are never stalled
module flash_write_combining_buffer_core #(
    parameter int unsigned FIFO_DEPTH = fwcb_pkg::FIFO_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [39:0]                     s_axis_tdata,  // [31:0] address, [39:32] data_byte
    input  logic [0:0]                      s_axis_tuser,  // [0] mode
    // master side
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [95:0]                     m_axis_tdata,  // [31:0] word_address, [95:32] word_value
    output logic [0:0]                      m_axis_tuser,  // [0] kind
    output logic                            m_axis_tlast,
    // configuration
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fwcb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fwcb_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fwcb_pkg::*;

    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    logic [ADDR_W-1:0] r_base;
    logic [ADDR_W-1:0] r_len;
    logic [ADDR_W:0]   r_limit;

    logic              r_in_vld;
    logic              r_in_mode;
    logic [ADDR_W-1:0] r_in_addr;
    logic [BYTE_W-1:0] r_in_data;

    t_push             w_push;
    t_result           w_head;
    logic [CNT_W-1:0]  w_count;
    logic [CNT_W:0]    w_need;
    logic              s_accept;

    // configuration registers, limit computed without wrap
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_len   <= '0;
            r_limit <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_REGION_BASE) begin
                    r_base <= i_cfg_data;
                end else if (i_cfg_index == REG_REGION_LENGTH) begin
                    r_len <= i_cfg_data;
                end
            end
            r_limit <= {1'b0, r_base} + {1'b0, r_len};
        end
    end

    // room for the item in flight and the new one, two results each
    assign w_need        = {1'b0, w_count} + (r_in_vld ? (CNT_W+1)'(2) : '0);
    assign s_axis_tready = (w_need <= (CNT_W+1)'(FIFO_DEPTH - 2));
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= s_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_mode <= s_axis_tuser[0];
            r_in_addr <= s_axis_tdata[31:0];
            r_in_data <= s_axis_tdata[39:32];
        end
    end

    fwcb_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_vld),
        .i_mode      (r_in_mode),
        .i_address   (r_in_addr),
        .i_data_byte (r_in_data),
        .i_limit     (r_limit),
        .o_push      (w_push)
    );

    fwcb_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_head  (w_head),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_count (w_count)
    );

    // output packing
    assign m_axis_tdata = {w_head.word_value, w_head.word_address};
    assign m_axis_tuser = w_head.kind;
    assign m_axis_tlast = w_head.last;

    // queue never overfills
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    // the second result of an item follows its first without a gap
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
        else $error("second result of an item missing");

    // every flushed word is aligned
    a_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OFF_W-1:0] == '0))
        else $error("unaligned word address");

    // a merge that pushes results needs an item in flight
    a_push_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.num != 2'd0) |-> $past(s_accept))
        else $error("result without an accepted item");

endmodule

[sim/flash_write_combining_buffer_core_test.sv]
// self-checking testbench of the flash write-combining buffer core
module flash_write_combining_buffer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fwcb_pkg::*;

    localparam int DIR_ROWS       = 29;
    localparam int RAND_PHASES    = 7;
    localparam int RAND_PER_PHASE = 240;
    localparam int TAIL_CYCLES    = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int IDLE_PCT       = 21;

    // register index that no register answers to
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_REGION_LENGTH + 8'd1;

    // how a directed row is handled
    typedef enum logic [1:0] {
        ROW_ITEM_MODEL,  // item, results from the model of the buffer
        ROW_ITEM_ONE,    // item, one result typed in the row
        ROW_ITEM_NONE,   // item, typed to cause nothing
        ROW_CFG          // register write: addr holds the value, data the index
    } t_row_op;

    typedef struct {
        t_row_op            op;
        logic               mode;
        logic [ADDR_W-1:0]  addr;
        logic [BYTE_W-1:0]  data;
        logic               kind;
        logic [ADDR_W-1:0]  waddr;
        logic [VALUE_W-1:0] wval;
    } t_row;

    // dut ports
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata;   // [31:0] address, [39:32] data_byte
    logic [0:0]            s_axis_tuser;   // [0] mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [95:0]           m_axis_tdata;   // [31:0] word_address, [95:32] word_value
    logic [0:0]            m_axis_tuser;   // [0] kind
    logic                  m_axis_tlast;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // model of the combining buffer
    logic [ADDR_W-1:0] cfg_base   = '0;
    logic [ADDR_W-1:0] cfg_length = '0;
    logic [ADDR_W-1:0] held_addr  = '0;
    logic              held_valid = 1'b0;
    logic              held_dirty = 1'b0;
    logic [BYTE_W-1:0] held_bytes [WORD_BYTES] = '{default: ERASED_BYTE};

    t_result made_now [$];   // words flushed by the latest item
    t_result due_words [$];  // flushed words not yet seen on the master side

    // run control and bookkeeping
    bit calm     = 1'b0;
    int hold_req = 0;
    int errors   = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int settings_run = 0;

    t_row dir_rows [DIR_ROWS];

    flash_write_combining_buffer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("flash_write_combining_buffer_core regression: fail");
        $finish;
    end

    // flush the held word if it carries written bytes
    function automatic void emit_word();
        logic [VALUE_W-1:0] value;
        logic [ADDR_W:0]    top;
        t_result            r;
        if (!(held_valid && held_dirty))
            return;
        value = '0;
        for (int i = WORD_BYTES - 1; i >= 0; i--)
            value = (value << 8) | VALUE_W'(held_bytes[i]);
        // region end taken without wrap
        top = {1'b0, cfg_base} + {1'b0, cfg_length};
        r.kind         = ({1'b0, held_addr} >= top) ? KIND_DISCARD : KIND_PROGRAM;
        r.word_address = held_addr;
        r.word_value   = value;
        r.last         = 1'b0;
        made_now.push_back(r);
        held_bytes = '{default: ERASED_BYTE};
        held_addr  = '0;
        held_valid = 1'b0;
        held_dirty = 1'b0;
    endfunction

    // merge one accepted item into the model, results land in made_now
    function automatic void merge_item(input logic mode, input logic [ADDR_W-1:0] addr,
                                       input logic [BYTE_W-1:0] data);
        logic [OFF_W-1:0]  off;
        logic [ADDR_W-1:0] aligned;
        logic [ADDR_W-1:0] next_addr;
        t_result           tail;
        made_now.delete();
        off     = addr[OFF_W-1:0];
        aligned = addr & ~ADDR_W'(WORD_BYTES - 1);
        if (mode == MODE_FLUSH) begin
            emit_word();
        end else begin
            if (!held_valid || aligned != held_addr) begin
                emit_word();
                held_addr  = aligned;
                held_valid = 1'b1;
            end
            held_bytes[off] = data;
            held_dirty      = 1'b1;
            // last byte of the word: flush and move on, wrapping at the top
            if (&off) begin
                next_addr = held_addr + ADDR_W'(WORD_BYTES);
                emit_word();
                held_addr  = next_addr;
                held_valid = 1'b1;
            end
        end
        if (made_now.size() > 0) begin
            tail      = made_now.pop_back();
            tail.last = 1'b1;
            made_now.push_back(tail);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        $display("mismatch on result beat %0d, %s: got %h, want %h",
                 results_seen, what, got, want);
        errors++;
    endtask

    // offer one input beat and book its results once accepted
    task automatic send_item(input t_row_op chk, input logic mode,
                             input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] data,
                             input t_result typed);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data, addr};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        merge_item(mode, addr, data);
        items_sent++;
        case (chk)
            ROW_ITEM_MODEL: foreach (made_now[i]) due_words.push_back(made_now[i]);
            ROW_ITEM_ONE:   due_words.push_back(typed);
            default: ;
        endcase
    endtask

    task automatic stop_sending();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for every booked result, then let the pipeline run empty
    task automatic settle();
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_REGION_BASE)
            cfg_base = val;
        else if (idx == REG_REGION_LENGTH)
            cfg_length = val;
    endtask

    // receiver: random backpressure, long hold-offs on request
    initial begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (hold_seen != hold_req) begin
                hold_seen     = hold_req;
                hold_left     = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // result check, sampled mid-cycle for the handshake of the coming edge
    always @(negedge i_clk) begin : watch_results
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind         = m_axis_tuser[0];
            got.word_address = m_axis_tdata[31:0];
            got.word_value   = m_axis_tdata[95:32];
            got.last         = m_axis_tlast;
            results_seen++;
            if (due_words.size() == 0) begin
                report_mismatch("beat with nothing due", VALUE_W'(got.word_address), '0);
            end else begin
                want = due_words.pop_front();
                if (got.kind != want.kind)
                    report_mismatch("kind", VALUE_W'(got.kind), VALUE_W'(want.kind));
                if (got.word_address != want.word_address)
                    report_mismatch("word_address", VALUE_W'(got.word_address),
                                    VALUE_W'(want.word_address));
                if (got.word_value != want.word_value)
                    report_mismatch("word_value", got.word_value, want.word_value);
                if (got.last != want.last)
                    report_mismatch("last", VALUE_W'(got.last), VALUE_W'(want.last));
            end
        end
    end

    // stimulus
    initial begin : stimulus
        t_row              row;
        t_result           typed;
        logic [ADDR_W-1:0] phase_base [RAND_PHASES];
        logic [ADDR_W-1:0] phase_len  [RAND_PHASES];
        logic [ADDR_W:0]   top;
        logic [ADDR_W-1:0] cursor;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
        logic              mode;
        int                pick;
        int                dir_items;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;

        dir_rows = '{
            // registers still at reset: empty region, every word is discarded
            '{ROW_ITEM_NONE, MODE_FLUSH, 32'hFFFF_FFFF, 8'hFF, KIND_PROGRAM, 32'h0, 64'h0},
            '{ROW_ITEM_ONE,  MODE_WRITE, 32'h0000_0007, 8'hAB, KIND_DISCARD, 32'h0,
              64'hABFF_FFFF_FFFF_FFFF},
            '{ROW_ITEM_NONE, MODE_FLUSH, 32'h0, 8'h00, KIND_PROGRAM, 32'h0, 64'h0},
            // small region at 0x1000, plus a write to an index nobody owns
            '{ROW_CFG, MODE_WRITE, 32'h0000_1000, REG_REGION_BASE, KIND_PROGRAM, 32'h0, 64'h0},
            '{ROW_CFG, MODE_WRITE, 32'h0000_0100, REG_REGION_LENGTH, KIND_PROGRAM, 32'h0, 64'h0},
            '{ROW_CFG, MODE_WRITE, 32'hDEAD_BEEF, REG_SPARE, KIND_PROGRAM, 32'h0, 64'h0},
            '{ROW_ITEM_MODEL, MODE_WRITE, 32'h0000_1000, 8'h00, KIND_PROGRAM, 32'h0, 64'h0},
            '{ROW_ITEM_MODEL, MODE_WRITE, 32'h0000_1003, 8'h5A, KIND_PROGRAM, 32'h0, 64'h0},
            '{ROW_ITEM_MODEL, MODE_WRITE, 32'h0000_10F8, 8'h11, KIND_PROGRAM, 32'h0, 64'h0},
            '{ROW_ITEM_MODEL, MODE_WRITE, 32'h0000_10FF, 8'h22, KIND_PROGRAM, 32'h0, 64'h0},
            '{ROW_ITEM_MODEL, MODE_WRITE, 32'h0000_1100, 8'h33, KIND_PROGRAM, 32'h0, 64'h0},
            '{ROW_ITEM_MODEL, MODE_FLUSH, 32'h0, 8'h00, KIND_PROGRAM, 32'h0, 64'h0},
            '{ROW_ITEM_MODEL, MODE_WRITE, 32'h0000_0FFC, 8'h44, KIND_PROGRAM, 32'h0, 64'h0},
            '{ROW_ITEM_MODEL, MODE_WRITE, 32'h0000_2007, 8'h55, KIND_PROGRAM, 32'h0, 64'h0},
            '{ROW_ITEM_MODEL, MODE_WRITE, 32'hFFFF_FFFF, 8'h00, KIND_PROGRAM, 32'h0, 64'h0},
            '{ROW_ITEM_MODEL, MODE_WRITE, 32'h0000_0000, 8'hFF, KIND_PROGRAM, 32'h0, 64'h0},
            '{ROW_ITEM_MODEL, MODE_FLUSH, 32'h0, 8'h00, KIND_PROGRAM, 32'h0, 64'h0},
            // region running past the top of the address space
            '{ROW_CFG, MODE_WRITE, 32'hFFFF_FFFF, REG_REGION_BASE, KIND_PROGRAM, 32'h0, 64'h0},
            '{ROW_CFG, MODE_WRITE, 32'hFFFF_FFFF, REG_REGION_LENGTH, KIND_PROGRAM, 32'h0, 64'h0},
            '{ROW_ITEM_MODEL, MODE_WRITE, 32'hFFFF_FFF9, 8'h80, KIND_PROGRAM, 32'h0, 64'h0},
            '{ROW_ITEM_MODEL, MODE_WRITE, 32'hFFFF_FFFF, 8'h01, KIND_PROGRAM, 32'h0, 64'h0},
            '{ROW_ITEM_MODEL, MODE_WRITE, 32'h0000_0005, 8'h7F, KIND_PROGRAM, 32'h0, 64'h0},
            '{ROW_ITEM_MODEL, MODE_WRITE, 32'h8000_0000, 8'hC3, KIND_PROGRAM, 32'h0, 64'h0},
            '{ROW_ITEM_MODEL, MODE_FLUSH, 32'h0, 8'h00, KIND_PROGRAM, 32'h0, 64'h0},
            // back to an empty region
            '{ROW_CFG, MODE_WRITE, 32'h0, REG_REGION_BASE, KIND_PROGRAM, 32'h0, 64'h0},
            '{ROW_CFG, MODE_WRITE, 32'h0, REG_REGION_LENGTH, KIND_PROGRAM, 32'h0, 64'h0},
            '{ROW_ITEM_MODEL, MODE_WRITE, 32'h1234_5678, 8'h96, KIND_PROGRAM, 32'h0, 64'h0},
            '{ROW_ITEM_MODEL, MODE_WRITE, 32'h1234_5679, 8'h69, KIND_PROGRAM, 32'h0, 64'h0},
            '{ROW_ITEM_MODEL, MODE_FLUSH, 32'h0, 8'h00, KIND_PROGRAM, 32'h0, 64'h0}
        };

        // region settings of the random phases, extremes first
        phase_base = '{32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h8000_0000};
        phase_len  = '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h8000_0000};
        phase_base[4] = $urandom();
        phase_len[4]  = $urandom();
        phase_base[5] = $urandom();
        phase_len[5]  = $urandom_range(4096);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        dir_items = 0;
        settings_run = 1;
        for (int r = 0; r < DIR_ROWS; r++) begin
            row = dir_rows[r];
            if (row.op == ROW_CFG) begin
                if (s_axis_tvalid)
                    stop_sending();
                settle();
                write_reg(row.data, row.addr);
                if (row.data == REG_REGION_LENGTH)
                    settings_run++;
            end else begin
                typed.kind         = row.kind;
                typed.word_address = row.waddr;
                typed.word_value   = row.wval;
                typed.last         = 1'b1;
                send_item(row.op, row.mode, row.addr, row.data, typed);
                dir_items++;
            end
        end

        // random phases: mostly byte streams, with jumps, flushes and noise
        typed = '0;
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (s_axis_tvalid)
                stop_sending();
            settle();
            write_reg(REG_REGION_BASE, phase_base[p]);
            write_reg(REG_REGION_LENGTH, phase_len[p]);
            if (p == 4)
                write_reg(REG_SPARE, $urandom());
            settings_run++;
            calm   = (p == 2);
            top    = {1'b0, cfg_base} + {1'b0, cfg_length};
            cursor = top[ADDR_W-1:0] - 32'd20;
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                // fill the output queue against a long receiver hold-off
                if (p == 4 && n == 20)
                    hold_req++;
                // sender pause until the block has delivered everything
                if (p == 1 && n == 120) begin
                    stop_sending();
                    settle();
                end
                pick = $urandom_range(99);
                mode = MODE_WRITE;
                data = BYTE_W'($urandom_range(255));
                if (pick < 10) begin
                    mode = MODE_FLUSH;
                    addr = $urandom();
                end else if (pick < 55) begin
                    addr = cursor + 32'd1;
                end else if (pick < 70) begin
                    addr = (cursor & ~ADDR_W'(WORD_BYTES - 1)) |
                           ADDR_W'($urandom_range(WORD_BYTES - 1));
                end else if (pick < 80) begin
                    addr = top[ADDR_W-1:0] - 32'd32 + ADDR_W'($urandom_range(63));
                end else if (pick < 90) begin
                    addr = $urandom_range(1) ? ADDR_W'($urandom_range(31))
                                             : 32'hFFFF_FFE0 + ADDR_W'($urandom_range(31));
                end else begin
                    addr = $urandom();
                end
                if (mode == MODE_WRITE)
                    cursor = addr;
                send_item(ROW_ITEM_MODEL, mode, addr, data, typed);
            end
        end
        calm = 1'b0;

        if (s_axis_tvalid)
            stop_sending();
        settle();

        $display("covered %0d input beats (%0d directed) under %0d region settings",
                 items_sent, dir_items, settings_run);
        $display("checked %0d result beats, %0d mismatches", results_seen, errors);
        if (errors == 0)
            $display("flash_write_combining_buffer_core regression: pass");
        else
            $display("flash_write_combining_buffer_core regression: fail");
        $finish;
    end

endmodule
